[rtl/hamt_pkg.sv]
// ============================================================================
// hamt_pkg: shared definitions for the hashed address map table
// Table geometry, entry layout, controller/datapath command and status
// structures, the bucket lookup table and the count saturation helper.
// ============================================================================
package hamt_pkg;

    localparam int BUCKETS   = 16;
    localparam int WAYS      = 4;
    localparam int ENTRIES   = BUCKETS * WAYS;

    localparam int NET_W     = 16;
    localparam int NODE_W    = 8;
    localparam int HW_W      = 48;
    localparam int COUNT_W   = 7;
    localparam int COUNT_MAX = 127;
    localparam int NODE_VALS = 256;

    localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCNT_W    = $clog2(WAYS + 1);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int CNT_WIDE  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic {
        OP_TOUCH  = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    typedef struct packed {
        logic              valid;
        logic [NET_W-1:0]  network;
        logic [NODE_W-1:0] node;
        logic [HW_W-1:0]   hw_addr;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              load;
        logic              clear_we;
        logic [ADDR_W-1:0] clear_addr;
        logic [WAY_W-1:0]  rd_way;
        logic              eval;
        logic [WAY_W-1:0]  eval_way;
        logic              commit;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    typedef logic [NODE_VALS-1:0][BKT_W-1:0] bucket_lut_t;

    // Bucket of every possible node number, worked out at elaboration.
    function automatic bucket_lut_t make_bucket_lut();
        bucket_lut_t lut;
        for (int i = 0; i < NODE_VALS; i++)
        begin
            lut[i] = BKT_W'(i % BUCKETS);
        end
        return lut;
    endfunction

    localparam bucket_lut_t BUCKET_LUT = make_bucket_lut();

    function automatic logic [COUNT_W-1:0] count_sat(input logic [CNT_W-1:0] c);
        logic [CNT_WIDE-1:0] wide;
        wide = CNT_WIDE'(c);
        if (wide > CNT_WIDE'(COUNT_MAX))
        begin
            return COUNT_W'(COUNT_MAX);
        end
        return wide[COUNT_W-1:0];
    endfunction

endpackage

[rtl/hamt_if.sv]
// ============================================================================
// hamt_if: request and response channels
// Valid/ready channels carrying one request item and one response item.
// ============================================================================
interface hamt_req_if;
    logic        valid;
    logic        ready;
    logic [0:0]  opcode;
    logic [15:0] network;
    logic [7:0]  node;
    logic [47:0] hw_addr;

    modport source (output valid, output opcode, output network, output node,
                    output hw_addr, input ready);
    modport sink   (input valid, input opcode, input network, input node,
                    input hw_addr, output ready);
endinterface

interface hamt_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [47:0] hw_addr_out;
    logic        bucket_full;
    logic [6:0]  entry_count;

    modport source (output valid, output found, output hw_addr_out,
                    output bucket_full, output entry_count, input ready);
    modport sink   (input valid, input found, input hw_addr_out,
                    input bucket_full, input entry_count, output ready);
endinterface

[rtl/hamt_ram.sv]
// ============================================================================
// hamt_ram: generic single-port-write RAM
// One write port and one read port, read data registered.
// ============================================================================
module hamt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/hamt_ctrl.sv]
// ============================================================================
// hamt_ctrl: sequencing controller
// Runs the clearing pass after reset, then accepts items one at a time,
// walks the ways of the bucket and commits the update and the response.
// ============================================================================
module hamt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  hamt_pkg::status_t status,
    output hamt_pkg::cmd_t    cmd
);
    import hamt_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clear_cnt_reg, clear_cnt_next;
    logic [WCNT_W-1:0]   way_cnt_reg, way_cnt_next;
    logic [WCNT_W-1:0]   way_prev;

    assign way_prev = way_cnt_reg - WCNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        way_cnt_next   = way_cnt_reg;
        req_ready      = 1'b0;
        cmd            = '0;
        cmd.clear_addr = clear_cnt_reg;
        cmd.rd_way     = way_cnt_reg[WAY_W-1:0];
        cmd.eval_way   = way_prev[WAY_W-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we   = 1'b1;
                clear_cnt_next = clear_cnt_reg + ADDR_W'(1);
                if (clear_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load     = 1'b1;
                    way_cnt_next = '0;
                    state_next   = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // Each cycle reads one way and judges the way read before it, if there was one.
                cmd.eval     = (way_cnt_reg != '0);
                way_cnt_next = way_cnt_reg + WCNT_W'(1);
                if (way_cnt_reg == WCNT_W'(WAYS))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            way_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            way_cnt_reg   <= way_cnt_next;
        end
    end

    a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == ST_SEARCH && way_cnt_reg == '0))
        else $error("accepted item did not start a bucket search");

    a_commit_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> req_ready)
        else $error("input not ready after commit");

    a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_we |-> (!cmd.eval && !cmd.commit && !req_ready))
        else $error("clearing pass overlaps item processing");

endmodule

[rtl/hamt_dp.sv]
// ============================================================================
// hamt_dp: table datapath
// Holds the current item, judges the ways read from the entry RAM, forms
// the RAM write and keeps the entry count and the response register.
// ============================================================================
module hamt_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hamt_pkg::cmd_t                cmd,
    output hamt_pkg::status_t             status,
    input  logic [0:0]                    req_opcode,
    input  logic [hamt_pkg::NET_W-1:0]    req_network,
    input  logic [hamt_pkg::NODE_W-1:0]   req_node,
    input  logic [hamt_pkg::HW_W-1:0]     req_hw_addr,
    output logic                          ram_we,
    output logic [hamt_pkg::ADDR_W-1:0]   ram_waddr,
    output logic [hamt_pkg::ENTRY_W-1:0]  ram_wdata,
    output logic [hamt_pkg::ADDR_W-1:0]   ram_raddr,
    input  logic [hamt_pkg::ENTRY_W-1:0]  ram_rdata,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic                          rsp_found,
    output logic [hamt_pkg::HW_W-1:0]     rsp_hw_addr_out,
    output logic                          rsp_bucket_full,
    output logic [hamt_pkg::COUNT_W-1:0]  rsp_entry_count
);
    import hamt_pkg::*;

    logic [0:0]          op_reg;
    logic [NET_W-1:0]    net_reg;
    logic [NODE_W-1:0]   node_reg;
    logic [HW_W-1:0]     hw_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic                hit_reg, hit_next;
    logic [WAY_W-1:0]    hit_way_reg;
    logic [HW_W-1:0]     hit_hw_reg;
    logic                free_reg, free_next;
    logic [WAY_W-1:0]    free_way_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic                found_reg;
    logic [HW_W-1:0]     hw_out_reg;
    logic                full_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    entry_t              rd_entry;
    entry_t              wr_entry;
    logic                match;
    logic                is_touch;
    logic                do_insert;
    logic                do_write;
    logic [WAY_W-1:0]    wr_way;

    assign rd_entry  = entry_t'(ram_rdata);
    assign match     = rd_entry.valid && (rd_entry.network == net_reg)
                       && (rd_entry.node == node_reg);
    assign is_touch  = (op_reg == OP_TOUCH);
    assign do_insert = cmd.commit && is_touch && !hit_reg && free_reg;
    assign do_write  = cmd.commit && is_touch && (hit_reg || free_reg);
    assign wr_way    = hit_reg ? hit_way_reg : free_way_reg;

    always_comb
    begin
        wr_entry.valid   = 1'b1;
        wr_entry.network = net_reg;
        wr_entry.node    = node_reg;
        wr_entry.hw_addr = hw_reg;
    end

    assign ram_raddr = base_reg + ADDR_W'(cmd.rd_way);
    assign ram_we    = cmd.clear_we || do_write;
    assign ram_waddr = cmd.clear_we ? cmd.clear_addr : (base_reg + ADDR_W'(wr_way));
    assign ram_wdata = cmd.clear_we ? ENTRY_W'(0) : ENTRY_W'(wr_entry);

    always_comb
    begin
        hit_next  = hit_reg;
        free_next = free_reg;
        if (cmd.load)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        else if (cmd.eval)
        begin
            // A match in a later way wins; the first empty way is kept.
            if (match)
            begin
                hit_next = 1'b1;
            end
            else if (!rd_entry.valid)
            begin
                free_next = 1'b1;
            end
        end
    end

    assign count_next = count_reg + CNT_W'(do_insert);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req_opcode;
            net_reg  <= req_network;
            node_reg <= req_node;
            hw_reg   <= req_hw_addr;
            base_reg <= ADDR_W'(BUCKET_LUT[req_node] * WAYS);
        end
        if (cmd.eval && match)
        begin
            hit_way_reg <= cmd.eval_way;
            hit_hw_reg  <= rd_entry.hw_addr;
        end
        if (cmd.eval && !match && !rd_entry.valid && !free_reg)
        begin
            free_way_reg <= cmd.eval_way;
        end
        if (cmd.commit)
        begin
            found_reg     <= hit_reg;
            hw_out_reg    <= (!is_touch && hit_reg) ? hit_hw_reg : '0;
            full_reg      <= is_touch && !hit_reg && !free_reg;
            count_out_reg <= count_sat(count_next);
        end
    end

    assign status.out_busy = out_valid_reg && !rsp_ready;
    assign rsp_valid       = out_valid_reg;
    assign rsp_found       = found_reg;
    assign rsp_hw_addr_out = hw_out_reg;
    assign rsp_bucket_full = full_reg;
    assign rsp_entry_count = count_out_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count exceeds table size");

    a_rsp_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("response raised without a commit");

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(full_reg && found_reg))
        else $error("response reports both a hit and a full bucket");

endmodule

[rtl/hashed_address_map_table.sv]
// ============================================================================
// hashed_address_map_table: hashed address-resolution cache
// Maps a network/node protocol address to a hardware address in a
// bucketed, set-associative entry RAM with touch and lookup items.
// ============================================================================
//
//  Channel  Direction  Handshake    Payload
//  req      in         valid/ready  opcode, network, node, hw_addr
//  rsp      out        valid/ready  found, hw_addr_out, bucket_full, entry_count
//
// An item is accepted in the idle state. The bucket is walked through the single
// read port of the entry RAM, each way judged the cycle after its read, and a
// commit step then writes the entry and loads the response register, from which
// the response is presented. The next item is accepted only after that commit.
// After reset a clearing pass writes every entry with req.ready low. The
// response register lets the next item be accepted and searched while a
// response waits; the commit stalls until it is taken.
//
module hashed_address_map_table (
    input  logic      clk,
    input  logic      rst_n,
    hamt_req_if.sink  req,
    hamt_rsp_if.source rsp
);
    import hamt_pkg::*;

    cmd_t                cmd;
    status_t             status;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    hamt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    hamt_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .req_opcode      (req.opcode),
        .req_network     (req.network),
        .req_node        (req.node),
        .req_hw_addr     (req.hw_addr),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_found       (rsp.found),
        .rsp_hw_addr_out (rsp.hw_addr_out),
        .rsp_bucket_full (rsp.bucket_full),
        .rsp_entry_count (rsp.entry_count)
    );

    hamt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
